@@ sv/wfpt_pkg.sv @@
`timescale 1ns / 1ps

package wfpt_pkg;

  // Window geometry.
  localparam int WINDOW_DEPTH  = 512;
  localparam int WARMUP_FRAMES = 4;
  localparam int ADDR_W        = $clog2(WINDOW_DEPTH);
  localparam int FILL_W        = $clog2(WINDOW_DEPTH + 1);

  // Field widths.
  localparam int PERIOD_W   = 24;
  localparam int RATE_W     = 28;
  localparam int ELAPSED_W  = 48;
  localparam int FRAME_W    = 32;
  localparam int OUT_DATA_W = 128;

  // Rate is this numerator divided by the period, 8 fractional bits.
  localparam logic [RATE_W-1:0] RATE_NUM = 28'd256000000;

  // Restoring divider, one quotient bit per step.
  localparam int DIV_CNT_W = $clog2(RATE_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(RATE_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DECIDE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_FINISH,
    ST_EMIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic div_step;
    logic decide;
    logic scan_issue;
    logic finish;
    logic emit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_last;
    logic warmup;
    logic need_scan;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

@@ sv/wfpt_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module wfpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/wfpt_ctrl.sv @@
`timescale 1ns / 1ps

// Sequencer: divide, decide, optional window rescan, commit (skipped in warm-up), emit.
module wfpt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  wfpt_pkg::sts_t  sts,
  output wfpt_pkg::cmd_t  cmd
);

  wfpt_pkg::state_t state;
  wfpt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wfpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      wfpt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = wfpt_pkg::ST_DIV;
        end
      end
      wfpt_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = wfpt_pkg::ST_DECIDE;
        end
      end
      wfpt_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.warmup) begin
          state_next = wfpt_pkg::ST_EMIT;
        end else if (sts.need_scan) begin
          state_next = wfpt_pkg::ST_SCAN;
        end else begin
          state_next = wfpt_pkg::ST_FINISH;
        end
      end
      wfpt_pkg::ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_next = wfpt_pkg::ST_SCAN_LAST;
        end
      end
      wfpt_pkg::ST_SCAN_LAST: begin
        // The last read returns in this cycle.
        state_next = wfpt_pkg::ST_FINISH;
      end
      wfpt_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = wfpt_pkg::ST_EMIT;
      end
      wfpt_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = wfpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wfpt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/wfpt_dp.sv @@
`timescale 1ns / 1ps

// Datapath: divider, peak registers, window memories and output register.
module wfpt_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  wfpt_pkg::cmd_t                      cmd,
  output wfpt_pkg::sts_t                      sts,
  input  logic [wfpt_pkg::PERIOD_W-1:0]       in_period,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [wfpt_pkg::OUT_DATA_W-1:0]     out_data,
  output logic                                out_recorded
);

  localparam int AW = wfpt_pkg::ADDR_W;
  localparam int FW = wfpt_pkg::FILL_W;
  localparam int PW = wfpt_pkg::PERIOD_W;
  localparam int RW = wfpt_pkg::RATE_W;
  localparam int EW = wfpt_pkg::ELAPSED_W;
  localparam int NW = wfpt_pkg::FRAME_W;

  // Current item and divider.
  logic [PW-1:0]                  period;
  logic [PW-1:0]                  rem;
  logic [RW-1:0]                  quo;
  logic [wfpt_pkg::DIV_CNT_W-1:0] div_cnt;

  // Tracker state.
  logic [EW-1:0] elapsed;
  logic [NW-1:0] frame_num;
  logic [RW-1:0] best_rate;
  logic [NW-1:0] best_rate_frame;
  logic [PW-1:0] best_period;
  logic [NW-1:0] best_period_frame;
  logic [AW-1:0] wr_pos;
  logic [FW-1:0] fill;
  logic          recorded;

  // Scan control.
  logic          scan_r;
  logic          scan_p;
  logic [NW-1:0] scan_base;
  logic [AW-1:0] scan_i;
  logic [AW-1:0] scan_addr;
  logic          rd_pend;
  logic [AW-1:0] rd_idx;
  logic [RW-1:0] rd_rate;
  logic [PW-1:0] rd_period;

  // Divider step.
  logic [PW:0]   trial;
  logic          trial_ge;
  logic [PW:0]   trial_diff;

  assign trial      = {rem, quo[RW-1]};
  assign trial_ge   = trial >= {1'b0, period};
  assign trial_diff = trial - {1'b0, period};

  // Peak comparisons against the finished quotient.
  logic          rate_ge;
  logic          per_ge;
  logic [NW-1:0] age_r;
  logic [NW-1:0] age_p;
  logic          need_r;
  logic          need_p;
  logic          warm;

  assign rate_ge = quo >= best_rate;
  assign per_ge  = period >= best_period;
  assign age_r   = rate_ge ? '0 : frame_num - best_rate_frame;
  assign age_p   = per_ge ? '0 : frame_num - best_period_frame;
  assign need_r  = age_r > NW'(wfpt_pkg::WINDOW_DEPTH);
  assign need_p  = age_p > NW'(wfpt_pkg::WINDOW_DEPTH);
  assign warm    = (fill == '0) && (frame_num < NW'(wfpt_pkg::WARMUP_FRAMES));

  // Oldest stored slot.
  logic [FW:0]   oldest_wide;
  logic [FW:0]   oldest_mod;
  logic [AW-1:0] oldest;

  assign oldest_wide = (FW+1)'(wr_pos) + (FW+1)'(wfpt_pkg::WINDOW_DEPTH) - (FW+1)'(fill);
  assign oldest_mod  = (oldest_wide >= (FW+1)'(wfpt_pkg::WINDOW_DEPTH)) ?
                       oldest_wide - (FW+1)'(wfpt_pkg::WINDOW_DEPTH) : oldest_wide;
  assign oldest      = AW'(oldest_mod);

  logic [AW-1:0] scan_addr_inc;
  logic [AW-1:0] wr_pos_inc;

  assign scan_addr_inc = (scan_addr == AW'(wfpt_pkg::WINDOW_DEPTH - 1)) ? '0 : scan_addr + 1'b1;
  assign wr_pos_inc    = (wr_pos == AW'(wfpt_pkg::WINDOW_DEPTH - 1)) ? '0 : wr_pos + 1'b1;

  assign sts.div_last  = div_cnt == wfpt_pkg::DIV_LAST;
  assign sts.warmup    = warm;
  assign sts.need_scan = (need_r || need_p) && (fill != '0);
  assign sts.scan_last = scan_i == AW'(fill - FW'(1));
  assign sts.out_free  = !out_valid || out_ready;

  wfpt_ram #(
    .WIDTH (RW),
    .DEPTH (wfpt_pkg::WINDOW_DEPTH)
  ) u_rate_ram (
    .clk   (clk),
    .we    (cmd.finish),
    .waddr (wr_pos),
    .wdata (quo),
    .raddr (scan_addr),
    .rdata (rd_rate)
  );

  wfpt_ram #(
    .WIDTH (PW),
    .DEPTH (wfpt_pkg::WINDOW_DEPTH)
  ) u_period_ram (
    .clk   (clk),
    .we    (cmd.finish),
    .waddr (wr_pos),
    .wdata (period),
    .raddr (scan_addr),
    .rdata (rd_period)
  );

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      period  <= (in_period == '0) ? PW'(1) : in_period;
      rem     <= '0;
      quo     <= wfpt_pkg::RATE_NUM;
    end else if (cmd.div_step) begin
      rem <= trial_ge ? trial_diff[PW-1:0] : trial[PW-1:0];
      quo <= {quo[RW-2:0], trial_ge};
    end
    if (cmd.decide) begin
      scan_r    <= need_r;
      scan_p    <= need_p;
      scan_base <= frame_num - NW'(fill);
      scan_i    <= '0;
      scan_addr <= oldest;
    end else if (cmd.scan_issue) begin
      scan_i    <= scan_i + 1'b1;
      scan_addr <= scan_addr_inc;
    end
    rd_idx <= scan_i;
    if (cmd.emit) begin
      out_data     <= {elapsed, best_period, best_rate, quo};
      out_recorded <= recorded;
    end
  end

  // Control and tracker state.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt           <= '0;
      elapsed           <= '0;
      frame_num         <= '0;
      best_rate         <= '0;
      best_rate_frame   <= '0;
      best_period       <= '0;
      best_period_frame <= '0;
      wr_pos            <= '0;
      fill              <= '0;
      recorded          <= 1'b0;
      rd_pend           <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      rd_pend <= cmd.scan_issue;

      if (cmd.accept) begin
        div_cnt <= '0;
        elapsed <= elapsed + EW'((in_period == '0) ? PW'(1) : in_period);
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + 1'b1;
      end

      if (cmd.decide) begin
        if (warm) begin
          frame_num <= frame_num + 1'b1;
          recorded  <= 1'b0;
        end else begin
          if (rate_ge) begin
            best_rate       <= quo;
            best_rate_frame <= frame_num;
          end
          if (per_ge) begin
            best_period       <= period;
            best_period_frame <= frame_num;
          end
        end
      end

      // Rescan: the first entry is taken outright, later ones only if larger.
      if (rd_pend) begin
        if (scan_r && ((rd_idx == '0) || (rd_rate > best_rate))) begin
          best_rate       <= rd_rate;
          best_rate_frame <= scan_base + NW'(rd_idx);
        end
        if (scan_p && ((rd_idx == '0) || (rd_period > best_period))) begin
          best_period       <= rd_period;
          best_period_frame <= scan_base + NW'(rd_idx);
        end
      end

      if (cmd.finish) begin
        if (rate_ge) begin
          best_rate       <= quo;
          best_rate_frame <= frame_num;
        end
        if (per_ge) begin
          best_period       <= period;
          best_period_frame <= frame_num;
        end
        wr_pos    <= wr_pos_inc;
        if (fill != FW'(wfpt_pkg::WINDOW_DEPTH)) begin
          fill <= fill + 1'b1;
        end
        frame_num <= frame_num + 1'b1;
        recorded  <= 1'b1;
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/windowed_frame_peak_tracker.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Width  Contents
// s_axis    in   24     tdata: frame_period_us
// m_axis    out  128+1  tdata: frame_rate, peak_rate, peak_period_us, elapsed_us;
//                       tuser: recorded
//
// A word is accepted, passes through the restoring divider, a decision state,
// a commit state and a state that loads the output register once it is free;
// during warm-up the commit state is skipped.
// A peak that ages out triggers a rescan of the window memories, one entry a
// cycle, followed by a state that waits for the last registered read; the
// window holds at most 512 stored entries.
// Reset is synchronous and clears all tracker state at once; the window
// memories need no clearing pass. A stalled output holds its word while the
// next input word is already taken in and processed up to the output register.
module windowed_frame_peak_tracker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // [23:0] frame_period_us
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // [27:0] frame_rate, [55:28] peak_rate,
                                       // [79:56] peak_period_us, [127:80] elapsed_us
  output logic [0:0]   m_axis_tuser    // [0] recorded
);

  wfpt_pkg::cmd_t cmd;
  wfpt_pkg::sts_t sts;

  // The controller only sequences; all arithmetic and storage live in the
  // datapath.
  wfpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the divider, the two window memories, the peak
  // registers and the output register with its valid flag.
  wfpt_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_period    (s_axis_tdata),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_data     (m_axis_tdata),
    .out_recorded (m_axis_tuser[0])
  );

endmodule

@@ sv/wfpt_checker.sv @@
`timescale 1ns / 1ps

// Port-level checks for the frame peak tracker.
module wfpt_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [23:0]  s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser
);

  logic seen_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_rec <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser[0]) begin
      seen_rec <= 1'b1;
    end
  end

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // Warm-up never comes back once a frame has been recorded.
  a_no_rewarm: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && seen_rec |-> m_axis_tuser[0])
    else $error("warm-up word after a recorded frame");

  // A recorded frame never exceeds the rate peak.
  a_peak_ge: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[55:28] >= m_axis_tdata[27:0])
    else $error("frame rate above peak rate");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind windowed_frame_peak_tracker wfpt_checker u_wfpt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import wfpt_pkg::*;

  localparam int RANDOM_WORDS = 850;
  localparam int DRAIN_CYCLES = 600;
  localparam int MAX_REPORTS  = 10;

  // Same layout as m_axis_tdata: the first member of a packed struct is the
  // highest, so frame_rate lands in the lowest bits.
  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed;
    logic [PERIOD_W-1:0]  peak_period;
    logic [RATE_W-1:0]    peak_rate;
    logic [RATE_W-1:0]    rate;
  } stats_data_t;

  typedef struct packed {
    logic        recorded;
    stats_data_t data;
  } frame_report_t;

  // Shapes of the random stretches of frame periods.
  typedef enum logic [2:0] {
    SEG_STEADY,
    SEG_RAMP_UP,
    SEG_RAMP_DOWN,
    SEG_TIES,
    SEG_SPIKES,
    SEG_NOISE
  } segment_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [PERIOD_W-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [127:0]         m_axis_tdata;
  logic [0:0]           m_axis_tuser;

  windowed_frame_peak_tracker dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Periods waiting to be sent and the reports they are predicted to cause.
  logic [PERIOD_W-1:0] pending_periods[$];
  frame_report_t       expected_reports[$];

  int total_words;
  int words_sent;
  int words_checked;
  int recorded_words;
  int peak_rescans;
  int mismatches;

  // Shadow copy of the tracker state. Periods are kept at the rate width so
  // that one peak routine serves both windows.
  logic [RATE_W-1:0]    rate_hist   [WINDOW_DEPTH];
  logic [RATE_W-1:0]    period_hist [WINDOW_DEPTH];
  logic [ADDR_W-1:0]    next_slot = '0;
  logic [FILL_W-1:0]    stored = '0;
  logic [FRAME_W-1:0]   frame_count = '0;
  logic [RATE_W-1:0]    top_rate = '0;
  logic [FRAME_W-1:0]   top_rate_frame = '0;
  logic [RATE_W-1:0]    top_period = '0;
  logic [FRAME_W-1:0]   top_period_frame = '0;
  logic [ELAPSED_W-1:0] elapsed_total = '0;

  // Running maximum with newest-wins ties. Once the peak is older than the
  // window, the stored frames are searched oldest first and the first maximum
  // is kept; the current frame is then compared again and wins ties.
  function automatic void follow_peak(input bit on_period, input logic [RATE_W-1:0] value,
                                      inout logic [RATE_W-1:0] peak,
                                      inout logic [FRAME_W-1:0] peak_frame);
    logic [ADDR_W-1:0] slot;
    logic [RATE_W-1:0] entry;
    if (value >= peak) begin
      peak = value;
      peak_frame = frame_count;
    end
    if (FRAME_W'(frame_count - peak_frame) > WINDOW_DEPTH) begin
      peak_rescans++;
      slot = ADDR_W'(next_slot - stored);
      peak = '0;
      peak_frame = frame_count;
      for (int i = 0; i < stored; i++) begin
        entry = on_period ? period_hist[slot] : rate_hist[slot];
        if (i == 0 || entry > peak) begin
          peak = entry;
          peak_frame = frame_count - stored + i;
        end
        slot++;
      end
      if (value >= peak) begin
        peak = value;
        peak_frame = frame_count;
      end
    end
  endfunction

  function automatic void predict_frame(input logic [PERIOD_W-1:0] period_in);
    frame_report_t       report;
    logic [PERIOD_W-1:0] period;
    logic [RATE_W-1:0]   rate;
    period = (period_in == '0) ? PERIOD_W'(1) : period_in;
    rate = RATE_NUM / period;
    elapsed_total = elapsed_total + period;
    report.recorded = 1'b0;
    if (stored == '0 && frame_count < WARMUP_FRAMES) begin
      // Warm-up frames only count and add to the elapsed time.
      frame_count++;
    end else begin
      follow_peak(1'b0, rate, top_rate, top_rate_frame);
      follow_peak(1'b1, RATE_W'(period), top_period, top_period_frame);
      rate_hist[next_slot] = rate;
      period_hist[next_slot] = RATE_W'(period);
      next_slot++;
      if (stored < WINDOW_DEPTH)
        stored++;
      frame_count++;
      report.recorded = 1'b1;
      recorded_words++;
    end
    report.data.rate = rate;
    report.data.peak_rate = top_rate;
    report.data.peak_period = PERIOD_W'(top_period);
    report.data.elapsed = elapsed_total;
    expected_reports.push_back(report);
  endfunction

  // Three idling phases by progress: the sender rarely and the receiver
  // often, then the reverse, then no idling at all.
  function automatic int idle_percent(input int progress, input bool_sender);
    if (progress * 3 < total_words)
      return bool_sender ? 8 : 68;
    else if (progress * 3 < total_words * 2)
      return bool_sender ? 68 : 8;
    return 0;
  endfunction

  // Driver: a word is taken when tvalid and tready are both high at an edge.
  // The prediction is made at that same edge, so the expected reports stay in
  // the order the block sees its input words.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_frame(s_axis_tdata);
        words_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_periods.size() != 0 &&
            $urandom_range(99) >= idle_percent(words_sent, 1'b1)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_periods.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every output word is matched against the oldest expectation.
  always @(posedge clk) begin
    frame_report_t got;
    frame_report_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.data = m_axis_tdata;
        got.recorded = m_axis_tuser[0];
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("output word %0d arrived with nothing expected: rate %0d", words_checked,
                     got.data.rate);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("word %0d expected: rate %0d peak_rate %0d peak_period %0d elapsed %0d rec %0b",
                       words_checked, want.data.rate, want.data.peak_rate,
                       want.data.peak_period, want.data.elapsed, want.recorded);
              $display("word %0d actual:   rate %0d peak_rate %0d peak_period %0d elapsed %0d rec %0b",
                       words_checked, got.data.rate, got.data.peak_rate,
                       got.data.peak_period, got.data.elapsed, got.recorded);
            end
          end
        end
        words_checked++;
      end
      m_axis_tready <= ($urandom_range(99) >= idle_percent(words_checked, 1'b0));
    end
  end

  // Stimulus and end of run.
  initial begin
    int                  generated;
    int                  seg_len;
    int                  level;
    int                  pick;
    int                  value;
    segment_t            seg;
    logic [PERIOD_W-1:0] period;

    // Directed words. The first four fall in warm-up and include a zero and
    // the largest period. After that: a zero period giving the highest rate,
    // ties on both peaks, the smallest periods, bit patterns and display rates.
    pending_periods = '{24'd0, 24'hFFFFFF, 24'd1, 24'd1000,
                        24'd0, 24'd1, 24'hFFFFFF, 24'hFFFFFF, 24'd2, 24'd3, 24'd255,
                        24'd256000, 24'd256001, 24'd8333, 24'd16666, 24'd16667,
                        24'hAAAAAA, 24'h555555, 24'h800000, 24'h7FFFFF,
                        24'd1000000, 24'd16000};

    // Random stretches of frame periods. Most look like real display timing
    // so that peaks live long enough to age out of the window; ramps force
    // repeated rescans, tie stretches exercise first-maximum-wins, and short
    // noise bursts hit every period bit and the zero and tiny periods.
    generated = 0;
    while (generated < RANDOM_WORDS) begin
      pick = $urandom_range(19);
      seg = (pick < 8)  ? SEG_STEADY :
            (pick < 10) ? SEG_RAMP_UP :
            (pick < 12) ? SEG_RAMP_DOWN :
            (pick < 15) ? SEG_TIES :
            (pick < 18) ? SEG_SPIKES : SEG_NOISE;
      level = $urandom_range(40000, 4000);
      seg_len = (seg == SEG_NOISE) ? $urandom_range(8, 2) : $urandom_range(120, 10);
      for (int k = 0; k < seg_len && generated < RANDOM_WORDS; k++) begin
        case (seg)
          SEG_STEADY:    value = level - 500 + $urandom_range(1000);
          SEG_RAMP_UP:   value = level + k * 37;
          SEG_RAMP_DOWN: value = level - k * 29;
          SEG_TIES: begin
            case ($urandom_range(3))
              0:       value = 8333;
              1:       value = 16666;
              2:       value = 16667;
              default: value = 33333;
            endcase
          end
          SEG_SPIKES: begin
            if ($urandom_range(29) == 0)
              value = $urandom_range(16777215, 1000000);
            else
              value = level - 200 + $urandom_range(400);
          end
          default: begin
            if ($urandom_range(1) == 0)
              value = $urandom_range(3);
            else
              value = $urandom & 24'hFFFFFF;
          end
        endcase
        period = PERIOD_W'(value);
        pending_periods.push_back(period);
        generated++;
      end
    end
    total_words = pending_periods.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Every word has been taken once the queue is empty and tvalid is low.
    do @(posedge clk); while (pending_periods.size() != 0 || s_axis_tvalid);
    while (expected_reports.size() != 0) @(posedge clk);
    // Let a worst-case word time pass so a spurious output would be seen.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_reports.size() != 0)
      mismatches += expected_reports.size();

    $display("Sent %0d frame periods (%0d past warm-up), checked %0d output words.",
             words_sent, recorded_words, words_checked);
    $display("The window was searched for an aged-out peak %0d times; %0d mismatches.",
             peak_rescans, mismatches);
    if (mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

  // Watchdog: several times the slowest legal run, rescans on every word.
  initial begin
    #(64'd20_000_000);
    $display("testbench: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
sv/wfpt_pkg.sv
sv/wfpt_ram.sv
sv/wfpt_ctrl.sv
sv/wfpt_dp.sv
sv/windowed_frame_peak_tracker.sv
sv/wfpt_checker.sv
tb/testbench.sv
